@@ rtl/pncs_pkg.sv @@
// Shared types, constants and small helper functions for the periodic
// nearest-center search block. No dependencies.

package pncs_pkg;

   // Field widths fixed by the interface
   localparam int POS_W    = 24;
   localparam int RAD_W    = 18;
   localparam int SF_W     = 8;
   localparam int SF_FRAC  = 4;
   localparam int RATIO_W  = 19;
   localparam int IDX_OUT_W = 10;
   localparam int SQ_W     = 2 * POS_W;      // one squared axis separation
   localparam int SUM_W    = SQ_W + 2;       // sum of three squares
   localparam int CUT_W    = SF_W + RAD_W;   // search_factor * radius

   // Request codes
   localparam logic [1:0] REQ_STORE = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_BOX_SIZE      = 2'd0;
   localparam logic [1:0] CSR_SEARCH_FACTOR = 2'd1;
   localparam logic [1:0] CSR_MAX_DISTANCE  = 2'd2;

   // Register reset values
   localparam logic [POS_W-1:0] BOX_SIZE_RST      = 24'd13107200;
   localparam logic [SF_W-1:0]  SEARCH_FACTOR_RST = 8'd40;
   localparam logic [POS_W-1:0] MAX_DISTANCE_RST  = 24'd6553600;

   // Controller states
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_INIT = 8'b0000_0010,
      ST_SCAN = 8'b0000_0100,
      ST_ROOT = 8'b0000_1000,
      ST_SQR  = 8'b0001_0000,
      ST_PROJ = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   // One table entry
   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
      logic [RAD_W-1:0] rad;
   } entry_type;

   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // One restoring step of d mod box: subtract box << k when it fits
   function automatic logic [POS_W-1:0] mod_step(input logic [POS_W-1:0] d,
                                                 input logic [POS_W-1:0] box,
                                                 input int k);
      logic [2*POS_W-1:0] bk;
      bk = {{POS_W{1'b0}}, box} << k;
      if ({{POS_W{1'b0}}, d} >= bk)
         return d - bk[POS_W-1:0];
      else
         return d;
   endfunction

   // Minimum image: fold past half the box
   function automatic logic [POS_W-1:0] fold(input logic [POS_W-1:0] d,
                                             input logic [POS_W-1:0] box);
      if ((box != '0) && ({d, 1'b0} > {1'b0, box}))
         return box - d;
      else
         return d;
   endfunction

endpackage

@@ rtl/pncs_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Uses no package items; instantiated by the top level.

module pncs_isqrt #(
   parameter int VALUE_W = 50
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [VALUE_W-1:0]   value,
   output logic                 done,
   output logic [VALUE_W/2-1:0] root
);

   localparam int RW    = VALUE_W / 2;
   localparam int CNT_W = $clog2(RW + 1);

   logic [VALUE_W-1:0] val_ff;
   logic [RW+1:0]      rem_ff;
   logic [RW-1:0]      root_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff;
   logic               done_ff;

   logic [RW+3:0] rem_sh;
   logic [RW+3:0] trial;
   logic [RW+3:0] rem_sub;
   logic          fits;

   // Bring down the next bit pair and try root*4+1
   always_comb begin
      rem_sh  = {rem_ff, val_ff[VALUE_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      fits    = (rem_sh >= trial);
      rem_sub = rem_sh - trial;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(RW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         val_ff  <= val_ff << 2;
         rem_ff  <= fits ? rem_sub[RW+1:0] : rem_sh[RW+1:0];
         root_ff <= {root_ff[RW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ rtl/pncs_div.sv @@
// Iterative restoring divider with a saturating quotient, one bit per cycle.
// Uses no package items; instantiated by the top level.

module pncs_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 18,
   parameter int QUO_W = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quot
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DEN_W:0]   rem_ff;
   logic [QUO_W-1:0] lo_ff;
   logic [QUO_W-1:0] quot_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   logic             sat;
   logic [DEN_W+1:0] rem_sh;
   logic             fits;
   logic [DEN_W+1:0] rem_sub;

   always_comb begin
      sat     = (CMP_W'(num) >= (CMP_W'(den) << QUO_W));
      rem_sh  = {rem_ff, lo_ff[QUO_W-1]};
      fits    = (rem_sh >= {2'b00, den_ff});
      rem_sub = rem_sh - {2'b00, den_ff};
   end

   // Control: saturated quotients finish at once
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= ~sat;
            done_ff <= sat;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= (DEN_W + 1)'(num >> QUO_W);
         lo_ff   <= num[QUO_W-1:0];
         den_ff  <= den;
         quot_ff <= sat ? '1 : '0;
      end else if (run_ff) begin
         rem_ff  <= fits ? rem_sub[DEN_W:0] : rem_sh[DEN_W:0];
         lo_ff   <= lo_ff << 1;
         quot_ff <= {quot_ff[QUO_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/periodic_nearest_center_search_top.sv @@
// Periodic nearest-center search: center table, scan pipeline and controller.
// Depends on pncs_pkg, pncs_isqrt and pncs_div.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+------------------------------
//  request   | req_type, req_pos_x/y/z, req_center_.. | start & !busy
//  response  | rsp_found ... rsp_radius_ratio         | rsp_valid, one cycle, no stall
//  csr write | csr_index, csr_wdata                   | csr_we
//
//  Store, clear and unused codes complete in the idle state. A query scans one
//  table entry per cycle while no new best center holds the scan, through a
//  pipeline of table read, axis separation, modulo steps, fold and cutoff,
//  squares and sums. Every new best center drops the pipeline, restarts the scan
//  after it and runs the square root that sets the distance threshold; a final
//  root and ratio follow. Reset empties the table at once; responses cannot stall.

module periodic_nearest_center_search_top #(
   parameter int MAX_CENTERS = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [23:0] req_pos_x,
   input  logic [23:0] req_pos_y,
   input  logic [23:0] req_pos_z,
   input  logic [17:0] req_center_radius,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [9:0]  rsp_center_index,
   output logic [23:0] rsp_distance,
   output logic [23:0] rsp_projected_distance,
   output logic [17:0] rsp_matched_radius,
   output logic [18:0] rsp_radius_ratio
);

   localparam int AW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CW    = $clog2(MAX_CENTERS + 1);
   localparam int NUM_W = pncs_pkg::POS_W + FRAC_BITS;
   localparam int POS_W = pncs_pkg::POS_W;
   localparam int RAD_W = pncs_pkg::RAD_W;
   localparam int SQ_W  = pncs_pkg::SQ_W;
   localparam int SUM_W = pncs_pkg::SUM_W;
   localparam int NRED  = POS_W;

   typedef struct packed {
      logic [AW-1:0]    idx;
      logic [RAD_W-1:0] rad;
      logic [POS_W-1:0] dx;
      logic [POS_W-1:0] dy;
      logic [POS_W-1:0] dz;
   } lane_type;

   // ---------------- configuration ----------------
   logic [POS_W-1:0]          box_ff;
   logic [pncs_pkg::SF_W-1:0] sf_ff;
   logic [POS_W-1:0]          maxd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff  <= pncs_pkg::BOX_SIZE_RST;
         sf_ff   <= pncs_pkg::SEARCH_FACTOR_RST;
         maxd_ff <= pncs_pkg::MAX_DISTANCE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pncs_pkg::CSR_BOX_SIZE:      box_ff  <= csr_wdata;
            pncs_pkg::CSR_SEARCH_FACTOR: sf_ff   <= csr_wdata[pncs_pkg::SF_W-1:0];
            pncs_pkg::CSR_MAX_DISTANCE:  maxd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- controller registers ----------------
   pncs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic [SQ_W-1:0]     thr_ff, thr_in;
   logic                hit_ff, hit_in;
   logic [POS_W-1:0]    best_r_ff, best_r_in;
   logic [POS_W-1:0]    proj_ff, proj_in;
   logic [pncs_pkg::RATIO_W-1:0] ratio_ff, ratio_in;

   logic [AW-1:0]    best_idx_ff;
   logic [RAD_W-1:0] best_rad_ff;
   logic [SUM_W-1:0] best_sxy_ff;
   logic [POS_W-1:0] qx_ff, qy_ff, qz_ff;

   logic accept;
   logic issue_go;
   logic win;
   logic scan_end;
   logic any_vld;

   assign busy   = (state_ff != pncs_pkg::ST_IDLE);
   assign accept = start & ~busy;

   // ---------------- center table ----------------
   pncs_pkg::entry_type mem [MAX_CENTERS];
   pncs_pkg::entry_type rd_ff;
   logic                m_vld_ff;
   logic [AW-1:0]       m_idx_ff;

   // Write on store, drop when full
   always_ff @(posedge clock) begin
      if (accept && (req_type == pncs_pkg::REQ_STORE) && (count_ff < CW'(MAX_CENTERS)))
         mem[count_ff[AW-1:0]] <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z,
                                     rad: req_center_radius};
   end

   // Registered read at the scan address
   always_ff @(posedge clock) begin
      rd_ff    <= mem[issue_ff[AW-1:0]];
      m_idx_ff <= issue_ff[AW-1:0];
   end

   // Latch the query point
   always_ff @(posedge clock) begin
      if (accept) begin
         qx_ff <= req_pos_x;
         qy_ff <= req_pos_y;
         qz_ff <= req_pos_z;
      end
   end

   // ---------------- scan pipeline ----------------
   lane_type red_ff [NRED+1];
   logic     red_vld_ff [NRED+1];

   lane_type f_ff;
   logic     f_ok_ff, f_vld_ff;

   logic [AW-1:0]    q_idx_ff;
   logic [RAD_W-1:0] q_rad_ff;
   logic [SQ_W-1:0]  q_sx_ff, q_sy_ff, q_sz_ff;
   logic             q_ok_ff, q_vld_ff;

   logic [AW-1:0]    c_idx_ff;
   logic [RAD_W-1:0] c_rad_ff;
   logic [SUM_W-1:0] c_sxy_ff, c_s_ff;
   logic             c_ok_ff, c_vld_ff;

   logic [pncs_pkg::CUT_W-1:0] cut;
   logic [POS_W-1:0]           fx, fy, fz;
   logic                       red_any;

   // Valid bits: drop everything in flight on a new best
   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         q_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         for (int j = 0; j <= NRED; j++)
            red_vld_ff[j] <= 1'b0;
      end else begin
         m_vld_ff      <= issue_go;
         red_vld_ff[0] <= m_vld_ff & ~win;
         for (int j = 0; j < NRED; j++)
            red_vld_ff[j+1] <= red_vld_ff[j] & ~win;
         f_vld_ff <= red_vld_ff[NRED] & ~win;
         q_vld_ff <= f_vld_ff & ~win;
         c_vld_ff <= q_vld_ff & ~win;
      end
   end

   // Axis separations
   always_ff @(posedge clock) begin
      red_ff[0] <= '{idx: m_idx_ff, rad: rd_ff.rad,
                     dx: pncs_pkg::abs_diff(qx_ff, rd_ff.x),
                     dy: pncs_pkg::abs_diff(qy_ff, rd_ff.y),
                     dz: pncs_pkg::abs_diff(qz_ff, rd_ff.z)};
   end

   // Reduce modulo the box, one quotient bit per stage
   for (genvar j = 0; j < NRED; j++) begin : g_mod
      localparam int K = NRED - 1 - j;
      always_ff @(posedge clock) begin
         red_ff[j+1].idx <= red_ff[j].idx;
         red_ff[j+1].rad <= red_ff[j].rad;
         red_ff[j+1].dx  <= pncs_pkg::mod_step(red_ff[j].dx, box_ff, K);
         red_ff[j+1].dy  <= pncs_pkg::mod_step(red_ff[j].dy, box_ff, K);
         red_ff[j+1].dz  <= pncs_pkg::mod_step(red_ff[j].dz, box_ff, K);
      end
   end

   // Fold to the minimum image and apply the per-axis cutoff
   always_comb begin
      cut = sf_ff * red_ff[NRED].rad;
      fx  = pncs_pkg::fold(red_ff[NRED].dx, box_ff);
      fy  = pncs_pkg::fold(red_ff[NRED].dy, box_ff);
      fz  = pncs_pkg::fold(red_ff[NRED].dz, box_ff);
   end

   always_ff @(posedge clock) begin
      f_ff    <= '{idx: red_ff[NRED].idx, rad: red_ff[NRED].rad, dx: fx, dy: fy, dz: fz};
      f_ok_ff <= ({fx, 4'b0} <= (POS_W + pncs_pkg::SF_FRAC)'(cut))
               && ({fy, 4'b0} <= (POS_W + pncs_pkg::SF_FRAC)'(cut))
               && ({fz, 4'b0} <= (POS_W + pncs_pkg::SF_FRAC)'(cut));
   end

   // Squares
   always_ff @(posedge clock) begin
      q_idx_ff <= f_ff.idx;
      q_rad_ff <= f_ff.rad;
      q_ok_ff  <= f_ok_ff;
      q_sx_ff  <= f_ff.dx * f_ff.dx;
      q_sy_ff  <= f_ff.dy * f_ff.dy;
      q_sz_ff  <= f_ff.dz * f_ff.dz;
   end

   // Sums
   always_ff @(posedge clock) begin
      c_idx_ff <= q_idx_ff;
      c_rad_ff <= q_rad_ff;
      c_ok_ff  <= q_ok_ff;
      c_sxy_ff <= SUM_W'(q_sx_ff) + SUM_W'(q_sy_ff);
      c_s_ff   <= SUM_W'(q_sx_ff) + SUM_W'(q_sy_ff) + SUM_W'(q_sz_ff);
   end

   // floor(sqrt(s)) < B exactly when s < B*B
   always_comb begin
      red_any = 1'b0;
      for (int j = 0; j <= NRED; j++)
         red_any = red_any | red_vld_ff[j];
      any_vld  = m_vld_ff | red_any | f_vld_ff | q_vld_ff | c_vld_ff;
      win      = (state_ff == pncs_pkg::ST_SCAN) && c_vld_ff && c_ok_ff
               && (c_s_ff < SUM_W'(thr_ff));
      issue_go = (state_ff == pncs_pkg::ST_SCAN) && (issue_ff < count_ff) && !win;
      scan_end = (state_ff == pncs_pkg::ST_SCAN) && !win && (issue_ff == count_ff)
               && !any_vld;
   end

   // Hold the best candidate
   always_ff @(posedge clock) begin
      if (win) begin
         best_idx_ff <= c_idx_ff;
         best_rad_ff <= c_rad_ff;
         best_sxy_ff <= c_sxy_ff;
      end
   end

   // ---------------- arithmetic units ----------------
   logic                 sq_start;
   logic [SUM_W-1:0]     sq_value;
   logic                 sq_done;
   logic [SUM_W/2-1:0]   sq_root;
   logic                 dv_start;
   logic                 dv_done;
   logic [pncs_pkg::RATIO_W-1:0] dv_quot;

   assign sq_start = win | (scan_end & hit_ff);
   assign sq_value = win ? c_s_ff : best_sxy_ff;
   assign dv_start = (state_ff == pncs_pkg::ST_PROJ) && sq_done;

   pncs_isqrt #(
      .VALUE_W(SUM_W)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .done  (sq_done),
      .root  (sq_root)
   );

   pncs_div #(
      .NUM_W(NUM_W),
      .DEN_W(RAD_W),
      .QUO_W(pncs_pkg::RATIO_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   ({sq_root[POS_W-1:0], {FRAC_BITS{1'b0}}}),
      .den   (best_rad_ff),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   // ---------------- controller ----------------
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      issue_in  = issue_ff;
      thr_in    = thr_ff;
      hit_in    = hit_ff;
      best_r_in = best_r_ff;
      proj_in   = proj_ff;
      ratio_in  = ratio_ff;
      unique case (state_ff)
         pncs_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  pncs_pkg::REQ_STORE: begin
                     if (count_ff < CW'(MAX_CENTERS))
                        count_in = count_ff + 1'b1;
                  end
                  pncs_pkg::REQ_QUERY: state_in = pncs_pkg::ST_INIT;
                  pncs_pkg::REQ_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         pncs_pkg::ST_INIT: begin
            issue_in = '0;
            hit_in   = 1'b0;
            thr_in   = maxd_ff * maxd_ff;
            state_in = pncs_pkg::ST_SCAN;
         end
         pncs_pkg::ST_SCAN: begin
            if (win) begin
               hit_in   = 1'b1;
               issue_in = CW'(c_idx_ff) + 1'b1;
               state_in = pncs_pkg::ST_ROOT;
            end else if (scan_end) begin
               state_in = hit_ff ? pncs_pkg::ST_PROJ : pncs_pkg::ST_DONE;
            end else if (issue_go) begin
               issue_in = issue_ff + 1'b1;
            end
         end
         pncs_pkg::ST_ROOT: begin
            if (sq_done) begin
               best_r_in = sq_root[POS_W-1:0];
               state_in  = pncs_pkg::ST_SQR;
            end
         end
         pncs_pkg::ST_SQR: begin
            thr_in   = best_r_ff * best_r_ff;
            state_in = pncs_pkg::ST_SCAN;
         end
         pncs_pkg::ST_PROJ: begin
            if (sq_done) begin
               proj_in  = sq_root[POS_W-1:0];
               state_in = pncs_pkg::ST_DIV;
            end
         end
         pncs_pkg::ST_DIV: begin
            if (dv_done) begin
               ratio_in = dv_quot;
               state_in = pncs_pkg::ST_DONE;
            end
         end
         pncs_pkg::ST_DONE: state_in = pncs_pkg::ST_IDLE;
         default:           state_in = pncs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pncs_pkg::ST_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_ff    <= thr_in;
      best_r_ff <= best_r_in;
      proj_ff   <= proj_in;
      ratio_ff  <= ratio_in;
   end

   // ---------------- response ----------------
   logic [31:0] idx_wide;

   assign idx_wide               = 32'(best_idx_ff);
   assign rsp_valid              = (state_ff == pncs_pkg::ST_DONE);
   assign rsp_found              = hit_ff;
   assign rsp_center_index       = hit_ff ? idx_wide[pncs_pkg::IDX_OUT_W-1:0] : '0;
   assign rsp_distance           = hit_ff ? best_r_ff : '0;
   assign rsp_projected_distance = hit_ff ? proj_ff : '0;
   assign rsp_matched_radius     = hit_ff ? best_rad_ff : '0;
   assign rsp_radius_ratio       = hit_ff ? ratio_ff : '0;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for periodic_nearest_center_search_top.
// Depends on pncs_pkg and the block's RTL; predicts each query result in a scoreboard.
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         TABLE_DEPTH = 1024;
   localparam int         FILL_COUNT  = 200;

   typedef struct {
      bit        found;
      bit [9:0]  index;
      bit [23:0] distance;
      bit [23:0] proj;
      bit [17:0] radius;
      bit [18:0] ratio;
   } center_match_type;

   // Scoreboard: shadow table and registers, queue of predicted query results
   class center_scoreboard;
      bit [23:0]        box, max_dist;
      bit [7:0]         factor;
      bit [23:0]        cx[TABLE_DEPTH], cy[TABLE_DEPTH], cz[TABLE_DEPTH];
      bit [17:0]        crad[TABLE_DEPTH];
      int               loaded;
      int               errors;
      center_match_type pending_matches[$];

      function new();
         box      = pncs_pkg::BOX_SIZE_RST;
         factor   = pncs_pkg::SEARCH_FACTOR_RST;
         max_dist = pncs_pkg::MAX_DISTANCE_RST;
         loaded   = 0;
         errors   = 0;
      endfunction

      function void report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endfunction

      function void write_reg(logic [1:0] idx, bit [23:0] val);
         case (idx)
            pncs_pkg::CSR_BOX_SIZE:      box = val;
            pncs_pkg::CSR_SEARCH_FACTOR: factor = val[7:0];
            pncs_pkg::CSR_MAX_DISTANCE:  max_dist = val;
            default: ;
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned root, step;
         root = 0;
         step = 64'd1 << 62;
         while (step > v) step >>= 2;
         while (step != 0) begin
            if (v >= root + step) begin
               v -= root + step;
               root = (root >> 1) + step;
            end else begin
               root >>= 1;
            end
            step >>= 2;
         end
         return root;
      endfunction

      // Minimum-image separation along one axis
      function longint unsigned wrap_sep(bit [23:0] a, bit [23:0] b);
         longint unsigned d;
         d = (a > b) ? a - b : b - a;
         if (box != 0) begin
            d = d % box;
            if (d * 2 > box) d = box - d;
         end
         return d;
      endfunction

      function center_match_type nearest_center(bit [23:0] qx, bit [23:0] qy, bit [23:0] qz);
         center_match_type m;
         longint unsigned  best, cut, dx, dy, dz, sxy, r, best_proj, ratio;
         int               best_idx;
         m = '{default: 0};
         best = max_dist;
         best_idx = -1;
         best_proj = 0;
         for (int i = 0; i < loaded; i++) begin
            cut = longint'(factor) * crad[i];
            dx = wrap_sep(qx, cx[i]);
            dy = wrap_sep(qy, cy[i]);
            dz = wrap_sep(qz, cz[i]);
            if (dx * 16 > cut || dy * 16 > cut || dz * 16 > cut) continue;
            sxy = dx * dx + dy * dy;
            r = int_sqrt(sxy + dz * dz);
            if (r < best) begin
               best = r;
               best_idx = i;
               best_proj = int_sqrt(sxy);
            end
         end
         if (best_idx < 0) return m;
         if (crad[best_idx] == 0) begin
            ratio = 19'h7FFFF;
         end else begin
            ratio = (best_proj << 16) / crad[best_idx];
            if (ratio > 19'h7FFFF) ratio = 19'h7FFFF;
         end
         m.found    = 1;
         m.index    = best_idx[9:0];
         m.distance = best[23:0];
         m.proj     = best_proj[23:0];
         m.radius   = crad[best_idx];
         m.ratio    = ratio[18:0];
         return m;
      endfunction

      // Note an accepted request
      function void note_request(logic [1:0] kind, bit [23:0] x, bit [23:0] y,
                                 bit [23:0] z, bit [17:0] rad);
         case (kind)
            pncs_pkg::REQ_STORE: begin
               if (loaded < TABLE_DEPTH) begin
                  cx[loaded] = x;
                  cy[loaded] = y;
                  cz[loaded] = z;
                  crad[loaded] = rad;
                  loaded++;
               end
            end
            pncs_pkg::REQ_CLEAR: loaded = 0;
            pncs_pkg::REQ_QUERY: pending_matches.push_back(nearest_center(x, y, z));
            default: ;
         endcase
      endfunction

      function void check_result(center_match_type got);
         center_match_type exp;
         if (pending_matches.size() == 0) begin
            report_mismatch("response with no query outstanding");
            return;
         end
         exp = pending_matches.pop_front();
         if (got.found != exp.found)
            report_mismatch($sformatf("found %0d exp %0d", got.found, exp.found));
         if (got.index != exp.index)
            report_mismatch($sformatf("index %0d exp %0d", got.index, exp.index));
         if (got.distance != exp.distance)
            report_mismatch($sformatf("distance %0h exp %0h", got.distance, exp.distance));
         if (got.proj != exp.proj)
            report_mismatch($sformatf("projected %0h exp %0h", got.proj, exp.proj));
         if (got.radius != exp.radius)
            report_mismatch($sformatf("radius %0h exp %0h", got.radius, exp.radius));
         if (got.ratio != exp.ratio)
            report_mismatch($sformatf("ratio %0h exp %0h", got.ratio, exp.ratio));
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = pncs_pkg::REQ_STORE;
   logic [23:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [17:0] req_center_radius = '0;
   logic        csr_we = 0;
   logic [1:0]  csr_index = pncs_pkg::CSR_BOX_SIZE;
   logic [23:0] csr_wdata = '0;
   logic        rsp_valid, rsp_found;
   logic [9:0]  rsp_center_index;
   logic [23:0] rsp_distance, rsp_projected_distance;
   logic [17:0] rsp_matched_radius;
   logic [18:0] rsp_radius_ratio;

   center_scoreboard sb = new();
   bit               calm = 0;

   periodic_nearest_center_search_top dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Sample responses at the edge that ends their cycle
   always @(posedge clock) begin
      center_match_type got;
      if (!reset && rsp_valid) begin
         got.found    = rsp_found;
         got.index    = rsp_center_index;
         got.distance = rsp_distance;
         got.proj     = rsp_projected_distance;
         got.radius   = rsp_matched_radius;
         got.ratio    = rsp_radius_ratio;
         sb.check_result(got);
      end
   end

   // Drive one request and hold it until accepted
   task automatic send_request(logic [1:0] kind, bit [23:0] x, bit [23:0] y,
                               bit [23:0] z, bit [17:0] rad);
      if (!calm && $urandom_range(99) < 31) begin
         start <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1;
      req_type <= kind;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_center_radius <= rad;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, x, y, z, rad);
   endtask

   // Hold off until all queries are answered and the block is quiet
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending_matches.size() != 0 || busy) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, bit [23:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
   endtask

   task automatic apply_config(bit [23:0] box, bit [7:0] factor, bit [23:0] dist_max);
      drain();
      write_csr(pncs_pkg::CSR_BOX_SIZE, box);
      write_csr(pncs_pkg::CSR_SEARCH_FACTOR, {16'd0, factor});
      write_csr(pncs_pkg::CSR_MAX_DISTANCE, dist_max);
   endtask

   function automatic bit [23:0] near(bit [23:0] c, int unsigned spread);
      return c + 24'($urandom_range(0, spread)) - 24'(spread / 2);
   endfunction

   // Clustered centers with nearby queries, plus some noise
   task automatic random_phase(int items, int unsigned spread);
      bit [23:0] bx, by, bz;
      int        n;
      int        sent;
      sent = 0;
      while (sent < items) begin
         send_request(pncs_pkg::REQ_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom),
                      18'($urandom));
         bx = 24'($urandom); by = 24'($urandom); bz = 24'($urandom);
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            send_request(pncs_pkg::REQ_STORE, near(bx, spread), near(by, spread),
                         near(bz, spread),
                         ($urandom_range(3) == 0) ? 18'($urandom_range(1, 18'h3FFFF))
                                                  : 18'($urandom_range(1, spread)));
         for (int i = $urandom_range(1, 6); i > 0; i--) begin
            if ($urandom_range(9) == 0)
               send_request(pncs_pkg::REQ_QUERY, 24'($urandom), 24'($urandom),
                            24'($urandom), 18'($urandom));
            else
               send_request(pncs_pkg::REQ_QUERY, near(bx, spread), near(by, spread),
                            near(bz, spread), 18'($urandom));
         end
         if ($urandom_range(7) == 0)
            send_request(REQ_UNUSED, 24'($urandom), 24'($urandom), 24'($urandom),
                         18'($urandom));
         sent += n + 4;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty table, extremes, ties, unused code, clear
      calm = 1;
      send_request(pncs_pkg::REQ_QUERY, 0, 0, 0, 0);
      send_request(pncs_pkg::REQ_STORE, 0, 0, 0, 18'h3FFFF);
      send_request(pncs_pkg::REQ_STORE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
      send_request(pncs_pkg::REQ_STORE, 24'h010000, 0, 0, 18'h10000);
      send_request(pncs_pkg::REQ_STORE, 24'h010000, 0, 0, 18'h20000);
      send_request(pncs_pkg::REQ_QUERY, 0, 0, 0, 0);
      send_request(pncs_pkg::REQ_QUERY, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF);
      send_request(pncs_pkg::REQ_QUERY, 24'h008000, 0, 0, 0);
      send_request(pncs_pkg::REQ_QUERY, 24'h020000, 0, 0, 0);
      send_request(pncs_pkg::REQ_QUERY, 24'hC70000, 24'hC70000, 0, 0);
      send_request(REQ_UNUSED, 24'h123456, 24'h654321, 24'hABCDEF, 5);
      send_request(pncs_pkg::REQ_QUERY, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 0);
      send_request(pncs_pkg::REQ_CLEAR, 0, 0, 0, 0);
      send_request(pncs_pkg::REQ_QUERY, 0, 0, 0, 0);
      send_request(pncs_pkg::REQ_STORE, 24'h640000, 24'h640000, 24'h640000, 1);
      send_request(pncs_pkg::REQ_QUERY, 24'h640000, 24'h640000, 24'h640000, 0);
      send_request(pncs_pkg::REQ_QUERY, 24'h640001, 24'h640000, 24'h640000, 0);

      // Load a long table and scan it end to end
      apply_config(24'hFFFFFF, 8'hFF, 24'hFFFFFF);
      send_request(pncs_pkg::REQ_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < FILL_COUNT; i++)
         send_request(pncs_pkg::REQ_STORE, 24'(i) << 12, 24'(i) << 12, 24'h800000,
                      18'($urandom_range(1, 18'h3FFFF)));
      send_request(pncs_pkg::REQ_QUERY, 24'h0C7000, 24'h0C7000, 24'h800000, 0);
      send_request(pncs_pkg::REQ_QUERY, 24'h0C8000, 24'h0C8000, 24'h800000, 0);
      calm = 0;

      // Random phases over register settings, extremes included
      apply_config(pncs_pkg::BOX_SIZE_RST, pncs_pkg::SEARCH_FACTOR_RST,
                   pncs_pkg::MAX_DISTANCE_RST);
      random_phase(70, 24'h080000);
      apply_config(24'd1, 8'd255, 24'hFFFFFF);
      random_phase(50, 24'h0400);
      apply_config(24'hFFFFFF, 8'd1, 24'd1);
      random_phase(40, 24'h0400);
      apply_config(24'h100000, 8'd255, 24'hFFFFFF);
      calm = 1;
      random_phase(70, 24'h200000);
      calm = 0;
      apply_config(24'h040000, 8'd64, 24'h080000);
      random_phase(60, 24'h040000);
      apply_config(24'($urandom_range(1, 24'hFFFFFF)), 8'($urandom_range(1, 255)),
                   24'($urandom_range(1, 24'hFFFFFF)));
      random_phase(70, 24'h100000);

      drain();
      if (sb.pending_matches.size() != 0)
         sb.report_mismatch("queries left unanswered");
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
